@@ rtl/core/cms_pkg.sv @@
// Shared types, constants and helpers for the 3x3 color median select pipeline.
package cms_pkg;

    localparam int WIN_COUNT   = 9;
    localparam int MEDIAN_RANK = 4;
    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int KEY_W       = 10;
    localparam int RANK_W      = $clog2(WIN_COUNT);

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [RANK_W-1:0] rank_t;

    typedef pix_t [WIN_COUNT-1:0] pix_arr_t;
    typedef key_t [WIN_COUNT-1:0] key_arr_t;

    // row k, bit m: pixel m sorts ahead of pixel k
    typedef logic [WIN_COUNT-1:0][WIN_COUNT-1:0] prec_t;
    typedef logic [WIN_COUNT-1:0] sel_t;

    // channel sum red + green + blue
    function automatic key_t pixel_key(input pix_t p);
        key_t r;
        key_t g;
        key_t b;
        r = {2'b00, p[23:16]};
        g = {2'b00, p[15:8]};
        b = {2'b00, p[7:0]};
        return r + g + b;
    endfunction

    // number of pixels ahead of this one
    function automatic rank_t count_ahead(input logic [WIN_COUNT-1:0] row);
        rank_t n;
        n = '0;
        for (int i = 0; i < WIN_COUNT; i++)
        begin
            n = n + rank_t'(row[i]);
        end
        return n;
    endfunction

endpackage

@@ rtl/core/cms_ifs.sv @@
// Stream interfaces: 3x3 window beats in, median pixel beats out.
interface cms_win_if
    import cms_pkg::*;
();
    logic valid;
    logic ready;
    pix_t left_top;
    pix_t left_mid;
    pix_t left_bottom;
    pix_t mid_top;
    pix_t center;
    pix_t mid_bottom;
    pix_t right_top;
    pix_t right_mid;
    pix_t right_bottom;

    modport source (
        output valid, left_top, left_mid, left_bottom, mid_top, center,
               mid_bottom, right_top, right_mid, right_bottom,
        input  ready
    );
    modport sink (
        input  valid, left_top, left_mid, left_bottom, mid_top, center,
               mid_bottom, right_top, right_mid, right_bottom,
        output ready
    );
endinterface

interface cms_pix_if
    import cms_pkg::*;
();
    logic valid;
    logic ready;
    pix_t median_pixel;

    modport source (
        output valid, median_pixel,
        input  ready
    );
    modport sink (
        input  valid, median_pixel,
        output ready
    );
endinterface

@@ rtl/core/cms_key_stage.sv @@
// Stage 1: channel-sum keys for the nine window pixels.
module cms_key_stage
    import cms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  pix_arr_t up_pix,
    output logic     dn_valid,
    input  logic     dn_ready,
    output pix_arr_t dn_pix,
    output key_arr_t dn_key
);
    logic     valid_reg;
    pix_arr_t pix_reg;
    key_arr_t key_reg;
    key_arr_t key_next;

    assign up_ready = !valid_reg || dn_ready;

    // one adder tree per pixel
    always_comb
    begin
        for (int k = 0; k < WIN_COUNT; k++)
        begin
            key_next[k] = pixel_key(up_pix[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            pix_reg <= up_pix;
            key_reg <= key_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_pix   = pix_reg;
    assign dn_key   = key_reg;
endmodule

@@ rtl/core/cms_compare_stage.sv @@
// Stage 2: pairwise key compares with window-order tie break.
module cms_compare_stage
    import cms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  pix_arr_t up_pix,
    input  key_arr_t up_key,
    output logic     dn_valid,
    input  logic     dn_ready,
    output pix_arr_t dn_pix,
    output prec_t    dn_prec
);
    logic     valid_reg;
    pix_arr_t pix_reg;
    prec_t    prec_reg;
    prec_t    prec_next;

    assign up_ready = !valid_reg || dn_ready;

    // earlier window position wins on equal keys
    always_comb
    begin
        for (int k = 0; k < WIN_COUNT; k++)
        begin
            for (int m = 0; m < WIN_COUNT; m++)
            begin
                if (m < k)
                begin
                    prec_next[k][m] = (up_key[m] <= up_key[k]);
                end
                else if (m > k)
                begin
                    prec_next[k][m] = (up_key[m] < up_key[k]);
                end
                else
                begin
                    prec_next[k][m] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            pix_reg  <= up_pix;
            prec_reg <= prec_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_pix   = pix_reg;
    assign dn_prec  = prec_reg;
endmodule

@@ rtl/core/cms_rank_stage.sv @@
// Stage 3: per-pixel rank count and one-hot pick of the median rank.
module cms_rank_stage
    import cms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  pix_arr_t up_pix,
    input  prec_t    up_prec,
    output logic     dn_valid,
    input  logic     dn_ready,
    output pix_arr_t dn_pix,
    output sel_t     dn_sel
);
    logic     valid_reg;
    pix_arr_t pix_reg;
    sel_t     sel_reg;
    sel_t     sel_next;

    assign up_ready = !valid_reg || dn_ready;

    // ranks are a permutation, so exactly one pixel matches
    always_comb
    begin
        for (int k = 0; k < WIN_COUNT; k++)
        begin
            sel_next[k] = (count_ahead(up_prec[k]) == rank_t'(MEDIAN_RANK));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            pix_reg <= up_pix;
            sel_reg <= sel_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_pix   = pix_reg;
    assign dn_sel   = sel_reg;
endmodule

@@ rtl/core/color_median_select_3x3_unit.sv @@
// Top level: four-stage pipeline that picks the median pixel of a 3x3 RGB window.
//
//   channel  | dir | payload                          | beat
//   ---------+-----+----------------------------------+---------------------------
//   window   | in  | nine 24-bit pixels, column-major | one 3x3 window
//   result   | out | median_pixel, 24 bits            | one pixel per window
//
// One window is accepted per clock while no stall reaches the window input; each result
// passes the key sum, pairwise compare, rank count and output select registers in order.
// rst_n clears the stage valid bits asynchronously; payload registers hold no reset.
// A stalled result freezes only the stages that are full behind it, so bubbles
// are squeezed out and nothing is dropped or repeated.
module color_median_select_3x3_unit
    import cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cms_win_if.sink    window,
    cms_pix_if.source  result
);
    pix_arr_t win_pix;

    logic     s1_valid;
    logic     s1_ready;
    pix_arr_t s1_pix;
    key_arr_t s1_key;

    logic     s2_valid;
    logic     s2_ready;
    pix_arr_t s2_pix;
    prec_t    s2_prec;

    logic     s3_valid;
    logic     s3_ready;
    pix_arr_t s3_pix;
    sel_t     s3_sel;

    logic     out_valid_reg;
    pix_t     median_reg;
    pix_t     median_next;

    // window position order: column-major
    assign win_pix[0] = window.left_top;
    assign win_pix[1] = window.left_mid;
    assign win_pix[2] = window.left_bottom;
    assign win_pix[3] = window.mid_top;
    assign win_pix[4] = window.center;
    assign win_pix[5] = window.mid_bottom;
    assign win_pix[6] = window.right_top;
    assign win_pix[7] = window.right_mid;
    assign win_pix[8] = window.right_bottom;

    cms_key_stage u_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (window.valid),
        .up_ready (window.ready),
        .up_pix   (win_pix),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_pix   (s1_pix),
        .dn_key   (s1_key)
    );

    cms_compare_stage u_compare (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_pix   (s1_pix),
        .up_key   (s1_key),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_pix   (s2_pix),
        .dn_prec  (s2_prec)
    );

    cms_rank_stage u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_pix   (s2_pix),
        .up_prec  (s2_prec),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .dn_pix   (s3_pix),
        .dn_sel   (s3_sel)
    );

    // output stage: one-hot select of the median pixel
    assign s3_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        median_next = '0;
        for (int k = 0; k < WIN_COUNT; k++)
        begin
            median_next = median_next | (s3_pix[k] & {PIX_W{s3_sel[k]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid && s3_ready)
        begin
            median_reg <= median_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.median_pixel = median_reg;
endmodule
